// ===== sv/ccms_pkg.sv =====
`default_nettype none

package ccms_pkg;

    localparam int CNT_W        = 64;
    localparam int CPU_W        = 3;
    localparam int REF_W        = 32;
    localparam int TIME_W       = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int RATE_CFG_W   = 32;
    localparam int PERIOD_W     = 20;
    localparam int MAX_STEP_W   = 22;
    localparam int S_TDATA_W    = 96;
    localparam int M_TDATA_W    = 32;

    localparam int CPU_COUNT_DEF = 8;
    localparam int FRAC_BITS_DEF = 12;

    localparam logic [RATE_CFG_W-1:0] INITIAL_RATE_RST = 32'd3000000;
    localparam logic [PERIOD_W-1:0]   ADJUST_PERIOD_RST = 20'd60000;
    localparam logic [MAX_STEP_W-1:0] MAX_STEP_RST      = 22'd3600000;

    localparam logic [CNT_W-1:0] FIRST_DEADLINE = 64'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_RATE  = 2'd0,
        REG_ADJUST_PERIOD = 2'd1,
        REG_MAX_STEP      = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/calibrated_cycle_counter_ms_clock_core.sv =====
`default_nettype none

// Channel  Direction  Beat content
// s_       in         tdata: cycle_count[63:0], ref_ms[95:64]; tuser: cpu_index
// m_       out        tdata: time_ms[31:0]
// cfg_     in         write enable, register index, write data
//
// An item's result is set by the 64-iteration divider, one quotient bit per cycle. A passed
// deadline adds the ST_NEXT state, a rate recalibration a second divider pass, and a counter
// that runs backward skips the step division.
// Reset is synchronous, active low; it clears the entry flags, the global time and
// the sequencer and restores the register defaults, with no clearing pass.
// A finished result holds in the output register while the next item is taken;
// the sequencer waits before its own result until that register is free.

module calibrated_cycle_counter_ms_clock_core #(
    parameter int CPU_COUNT = ccms_pkg::CPU_COUNT_DEF,
    parameter int FRAC_BITS = ccms_pkg::FRAC_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [ccms_pkg::S_TDATA_W-1:0]  s_tdata,   // cycle_count, ref_ms
    input  wire logic [ccms_pkg::CPU_W-1:0]      s_tuser,   // cpu_index
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [ccms_pkg::M_TDATA_W-1:0]       m_tdata,   // time_ms
    input  wire logic                            cfg_wr_en,
    input  wire logic [ccms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ccms_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ccms_pkg::*;

    localparam int IDX_W = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_STEP, ST_DIV_STEP, ST_CLAMP, ST_ADD, ST_MONO,
        ST_CHECK, ST_DIV_RATE, ST_NEXT, ST_WB, ST_OUT
    } state_t;

    function automatic logic [IDX_W-1:0] entry_of(input logic [CPU_W-1:0] cpu);
        logic [CPU_W:0] v;
        v = {1'b0, cpu};
        for (int i = 0; i < (1 << CPU_W); i++) begin
            if (int'(v) >= CPU_COUNT) begin
                v = (CPU_W+1)'(int'(v) - CPU_COUNT);
            end
        end
        return IDX_W'(v);
    endfunction

    state_t                state_reg;
    logic [RATE_CFG_W-1:0] init_rate_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [MAX_STEP_W-1:0] max_step_reg;

    logic [CPU_COUNT-1:0]  started_reg;
    logic [CNT_W-1:0]      acc_mem    [CPU_COUNT];
    logic [CNT_W-1:0]      last_mem   [CPU_COUNT];
    logic [CNT_W-1:0]      rate_mem   [CPU_COUNT];
    logic [CNT_W-1:0]      nadj_mem   [CPU_COUNT];
    logic [CNT_W-1:0]      cadj_mem   [CPU_COUNT];
    logic [REF_W-1:0]      radj_mem   [CPU_COUNT];

    logic [CNT_W-1:0]      global_reg;
    logic [IDX_W-1:0]      ent_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [REF_W-1:0]      ref_reg;
    logic [CNT_W-1:0]      acc_reg;
    logic [CNT_W-1:0]      last_reg;
    logic [CNT_W-1:0]      rate_reg;
    logic [CNT_W-1:0]      nadj_reg;
    logic [CNT_W-1:0]      cadj_reg;
    logic [REF_W-1:0]      radj_reg;
    logic [CNT_W-1:0]      step_reg;
    logic                  m_tvalid_reg;
    logic [TIME_W-1:0]     m_tdata_reg;

    logic [IDX_W-1:0]      s_ent;
    logic [CNT_W-1:0]      s_count;
    logic [REF_W-1:0]      s_ref;
    logic [CNT_W-1:0]      start_rate;
    logic [CNT_W-1:0]      scaled;
    logic [CNT_W-1:0]      limit;
    logic [CNT_W-1:0]      rdiff;
    logic [CNT_W-1:0]      span;
    logic                  s_fire;
    logic                  out_free;

    logic                  div_start;
    logic [CNT_W-1:0]      div_dividend;
    logic [CNT_W-1:0]      div_divisor;
    logic                  div_done;
    logic [CNT_W-1:0]      div_quot;

    assign s_count    = s_tdata[CNT_W-1:0];
    assign s_ref      = s_tdata[CNT_W +: REF_W];
    assign s_ent      = entry_of(s_tuser);
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign start_rate = (init_rate_reg == '0) ? CNT_W'(1) : CNT_W'(init_rate_reg);
    assign scaled     = (cnt_reg - last_reg) << FRAC_BITS;
    assign limit      = CNT_W'(max_step_reg) << FRAC_BITS;
    assign rdiff      = cnt_reg - cadj_reg;
    assign span       = CNT_W'(ref_reg - radj_reg);

    always_comb begin
        div_start    = 1'b0;
        div_dividend = scaled;
        div_divisor  = rate_reg;
        case (state_reg)
            ST_STEP: begin
                div_start = !scaled[CNT_W-1];
            end
            ST_CHECK: begin
                div_dividend = rdiff;
                div_divisor  = span;
                div_start    = (acc_reg > nadj_reg) && (ref_reg > radj_reg)
                               && !rdiff[CNT_W-1];
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    ccms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            init_rate_reg <= INITIAL_RATE_RST;
            period_reg    <= ADJUST_PERIOD_RST;
            max_step_reg  <= MAX_STEP_RST;
            started_reg   <= '0;
            global_reg    <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_INITIAL_RATE:  init_rate_reg <= cfg_data[RATE_CFG_W-1:0];
                    REG_ADJUST_PERIOD: period_reg    <= cfg_data[PERIOD_W-1:0];
                    REG_MAX_STEP:      max_step_reg  <= cfg_data[MAX_STEP_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        ent_reg <= s_ent;
                        cnt_reg <= s_count;
                        ref_reg <= s_ref;
                        if (started_reg[s_ent]) begin
                            acc_reg  <= acc_mem[s_ent];
                            last_reg <= last_mem[s_ent];
                            rate_reg <= rate_mem[s_ent];
                            nadj_reg <= nadj_mem[s_ent];
                            cadj_reg <= cadj_mem[s_ent];
                            radj_reg <= radj_mem[s_ent];
                        end else begin
                            acc_reg  <= '0;
                            last_reg <= s_count;
                            rate_reg <= start_rate;
                            nadj_reg <= FIRST_DEADLINE;
                            cadj_reg <= s_count;
                            radj_reg <= s_ref;
                        end
                        state_reg <= ST_STEP;
                    end
                end
                ST_STEP: begin
                    if (scaled[CNT_W-1]) begin
                        step_reg  <= '0;
                        state_reg <= ST_CLAMP;
                    end else begin
                        state_reg <= ST_DIV_STEP;
                    end
                end
                ST_DIV_STEP: begin
                    if (div_done) begin
                        step_reg  <= div_quot;
                        state_reg <= ST_CLAMP;
                    end
                end
                ST_CLAMP: begin
                    if (step_reg > limit) begin
                        step_reg <= limit;
                    end
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    acc_reg   <= acc_reg + step_reg;
                    state_reg <= ST_MONO;
                end
                ST_MONO: begin
                    if (acc_reg >= global_reg) begin
                        global_reg <= acc_reg;
                    end else begin
                        acc_reg <= global_reg;
                    end
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (acc_reg > nadj_reg) begin
                        if (ref_reg > radj_reg) begin
                            if (rdiff[CNT_W-1]) begin
                                rate_reg  <= CNT_W'(1);
                                state_reg <= ST_NEXT;
                            end else begin
                                state_reg <= ST_DIV_RATE;
                            end
                        end else begin
                            state_reg <= ST_NEXT;
                        end
                    end else begin
                        state_reg <= ST_WB;
                    end
                end
                ST_DIV_RATE: begin
                    if (div_done) begin
                        rate_reg  <= (div_quot == '0) ? CNT_W'(1) : div_quot;
                        state_reg <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    nadj_reg  <= acc_reg + (CNT_W'(period_reg) << FRAC_BITS);
                    radj_reg  <= ref_reg;
                    cadj_reg  <= cnt_reg;
                    state_reg <= ST_WB;
                end
                ST_WB: begin
                    acc_mem[ent_reg]     <= acc_reg;
                    last_mem[ent_reg]    <= cnt_reg;
                    rate_mem[ent_reg]    <= rate_reg;
                    nadj_mem[ent_reg]    <= nadj_reg;
                    cadj_mem[ent_reg]    <= cadj_reg;
                    radj_mem[ent_reg]    <= radj_reg;
                    started_reg[ent_reg] <= 1'b1;
                    state_reg            <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_tdata_reg  <= acc_reg[FRAC_BITS +: TIME_W];
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== sv/ccms_div.sv =====
`default_nettype none

module ccms_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [ccms_pkg::CNT_W-1:0] dividend,
    input  wire logic [ccms_pkg::CNT_W-1:0] divisor,
    output logic                            done,
    output logic [ccms_pkg::CNT_W-1:0]      quotient
);
    import ccms_pkg::*;

    localparam int ITER_W = $clog2(CNT_W);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CNT_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  qd_reg;
    logic [CNT_W-1:0]  dvs_reg;

    logic [CNT_W:0]    part;
    logic [CNT_W+1:0]  diff;

    assign part = {rem_reg, qd_reg[CNT_W-1]};
    assign diff = {1'b0, part} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= busy_reg && !start && (iter_reg == LAST_ITER);
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
                rem_reg  <= '0;
                qd_reg   <= dividend;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                if (!diff[CNT_W+1]) begin
                    rem_reg <= diff[CNT_W-1:0];
                end else begin
                    rem_reg <= part[CNT_W-1:0];
                end
                qd_reg   <= {qd_reg[CNT_W-2:0], ~diff[CNT_W+1]};
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == LAST_ITER) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

`default_nettype wire

// ===== sv/ccms_checker.sv =====
`default_nettype none

module ccms_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ccms_pkg::M_TDATA_W-1:0]  m_tdata
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("input taken while an item is in progress");

    a_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("block not ready once its result is shown");

endmodule

bind calibrated_cycle_counter_ms_clock_core ccms_checker u_ccms_checker (.*);

`default_nettype wire

// ===== sim/tb_calibrated_cycle_counter_ms_clock_core.sv =====
`timescale 1ns / 100ps

module tb_calibrated_cycle_counter_ms_clock_core;

    import ccms_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int TAIL_CYCLES    = 160;
    localparam int NUM_SEGMENTS   = 12;
    localparam int SEG_ITEMS      = 62;
    localparam int NUM_ROWS       = 28;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CNT_W-1:0]       value;    // cycle_count, or register data
        logic [CPU_W-1:0]       cpu;
        logic [REF_W-1:0]       rms;
        logic                   typed;
        logic [TIME_W-1:0]      want;
    } script_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // cycle_count[63:0], ref_ms[95:64]
    logic [CPU_W-1:0]      s_tuser;   // cpu_index[2:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;   // time_ms[31:0]
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    calibrated_cycle_counter_ms_clock_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // register shadows
    logic [RATE_CFG_W-1:0] shadow_rate     = INITIAL_RATE_RST;
    logic [PERIOD_W-1:0]   shadow_period   = ADJUST_PERIOD_RST;
    logic [MAX_STEP_W-1:0] shadow_max_step = MAX_STEP_RST;

    // per-processor clock entries
    logic [CNT_W-1:0] acc_ms_q12 [CPU_COUNT_DEF] = '{default: '0};
    logic [CNT_W-1:0] prev_count [CPU_COUNT_DEF] = '{default: '0};
    logic [CNT_W-1:0] cpu_rate   [CPU_COUNT_DEF] = '{default: '0};
    logic [CNT_W-1:0] deadline   [CPU_COUNT_DEF] = '{default: '0};
    logic [CNT_W-1:0] cal_count  [CPU_COUNT_DEF] = '{default: '0};
    logic [REF_W-1:0] cal_ref    [CPU_COUNT_DEF] = '{default: '0};
    logic             entry_live [CPU_COUNT_DEF] = '{default: 1'b0};
    logic [CNT_W-1:0] global_acc = '0;

    logic [TIME_W-1:0] pending_time_ms [$];

    int unsigned samples_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned fail_count      = 0;
    int unsigned recal_count     = 0;
    int unsigned clamp_count     = 0;
    int unsigned backstep_count  = 0;
    int unsigned writes_done     = 0;
    int unsigned idle_cycles     = 0;

    bit sender_idles   = 1'b0;
    bit receiver_idles = 1'b0;
    bit hold_output    = 1'b0;

    // simulated processor counters for well-formed sequences
    logic [CNT_W-1:0] run_count [CPU_COUNT_DEF];
    logic [REF_W-1:0] run_ref   [CPU_COUNT_DEF];
    logic [CNT_W-1:0] speed     [CPU_COUNT_DEF];

    script_row_t script [NUM_ROWS] = '{
        '{ROW_SAMPLE, '0, 64'd0,                   3'd0, 32'd0,         1'b1, 32'd0},
        '{ROW_SAMPLE, '0, 64'd15_000_000,          3'd0, 32'd5,         1'b1, 32'd5},
        '{ROW_SAMPLE, '0, 64'd1000,                3'd0, 32'd6,         1'b1, 32'd5},
        '{ROW_SAMPLE, '0, 64'hFFFF_FFFF_FFFF_FFFF, 3'd1, 32'hFFFF_FFFF, 1'b1, 32'd5},
        '{ROW_SAMPLE, '0, 64'd2_999_999,           3'd1, 32'd0,         1'b0, '0},
        '{ROW_SAMPLE, '0, 64'h4000_0000_0000_0000, 3'd1, 32'd1,         1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd0,                   3'd2, 32'd100,       1'b0, '0},
        '{ROW_SAMPLE, '0, 64'h0008_0000_0000_0000, 3'd2, 32'd200,       1'b0, '0},
        '{ROW_SAMPLE, '0, 64'h000F_FFFF_FFFF_FFFF, 3'd2, 32'd300,       1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd0,                   3'd3, 32'd7,         1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd5_000_000_000,       3'd3, 32'd7,         1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_RATE,  64'd1,     3'd0, 32'd0,         1'b0, '0},
        '{ROW_WRITE, REG_ADJUST_PERIOD, 64'd1,     3'd0, 32'd0,         1'b0, '0},
        '{ROW_WRITE, REG_MAX_STEP,      64'd1,     3'd0, 32'd0,         1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd10,                  3'd4, 32'd50,        1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd11,                  3'd4, 32'd60,        1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd5,                   3'd4, 32'd70,        1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_RATE,  64'hFFFF_FFFF, 3'd0, 32'd0,     1'b0, '0},
        '{ROW_WRITE, REG_ADJUST_PERIOD, 64'h000F_FFFF, 3'd0, 32'd0,     1'b0, '0},
        '{ROW_WRITE, REG_MAX_STEP,      64'h003F_FFFF, 3'd0, 32'd0,     1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd123,                 3'd5, 32'd0,         1'b0, '0},
        '{ROW_SAMPLE, '0, 64'h0007_FFFF_FFFF_FFFF, 3'd5, 32'hFFFF_FFFF, 1'b0, '0},
        '{ROW_WRITE, REG_INITIAL_RATE,  64'd0,     3'd0, 32'd0,         1'b0, '0},
        '{ROW_WRITE, REG_SPARE,         64'hDEAD_BEEF, 3'd0, 32'd0,     1'b0, '0},
        '{ROW_WRITE, REG_ADJUST_PERIOD, 64'hFFF0_0010, 3'd0, 32'd0,     1'b0, '0},
        '{ROW_WRITE, REG_MAX_STEP,      64'hFFC0_1000, 3'd0, 32'd0,     1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd0,                   3'd6, 32'd1000,      1'b0, '0},
        '{ROW_SAMPLE, '0, 64'd77,                  3'd6, 32'd1001,      1'b0, '0}
    };

    function automatic logic [TIME_W-1:0] advance_clock(input logic [CNT_W-1:0] cnt,
                                                        input logic [CPU_W-1:0] cpu,
                                                        input logic [REF_W-1:0] rms);
        logic [CNT_W-1:0] scaled, step, limit, diff, span, quo;
        if (!entry_live[cpu]) begin
            prev_count[cpu] = cnt;
            cal_count[cpu]  = cnt;
            cal_ref[cpu]    = rms;
            deadline[cpu]   = FIRST_DEADLINE;
            cpu_rate[cpu]   = (shadow_rate == '0) ? 64'd1 : 64'(shadow_rate);
            entry_live[cpu] = 1'b1;
        end
        scaled = (cnt - prev_count[cpu]) << FRAC_BITS_DEF;
        if (scaled[CNT_W-1]) begin
            step = '0;
            backstep_count++;
        end else begin
            step = scaled / cpu_rate[cpu];
        end
        limit = 64'(shadow_max_step) << FRAC_BITS_DEF;
        if (step > limit) begin
            step = limit;
            clamp_count++;
        end
        acc_ms_q12[cpu] = acc_ms_q12[cpu] + step;
        prev_count[cpu] = cnt;
        if (acc_ms_q12[cpu] >= global_acc) begin
            global_acc = acc_ms_q12[cpu];
        end else begin
            acc_ms_q12[cpu] = global_acc;
        end
        if (acc_ms_q12[cpu] > deadline[cpu]) begin
            if (rms > cal_ref[cpu]) begin
                diff = cnt - cal_count[cpu];
                span = 64'(rms - cal_ref[cpu]);
                quo = diff[CNT_W-1] ? 64'd0 : diff / span;
                cpu_rate[cpu] = (quo == '0) ? 64'd1 : quo;
                recal_count++;
            end
            deadline[cpu]  = acc_ms_q12[cpu] + (64'(shadow_period) << FRAC_BITS_DEF);
            cal_ref[cpu]   = rms;
            cal_count[cpu] = cnt;
        end
        return acc_ms_q12[cpu][FRAC_BITS_DEF +: TIME_W];
    endfunction

    task automatic send_sample(input logic [CNT_W-1:0] cnt, input logic [CPU_W-1:0] cpu,
                               input logic [REF_W-1:0] rms, input logic typed,
                               input logic [TIME_W-1:0] want);
        logic [TIME_W-1:0] predicted;
        int unsigned gap;
        gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rms, cnt};
        s_tuser  <= cpu;
        do @(posedge aclk); while (!s_tready);
        predicted = advance_clock(cnt, cpu, rms);
        pending_time_ms.push_back(typed ? want : predicted);
        samples_sent++;
    endtask

    task automatic settle_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_time_ms.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_INITIAL_RATE:  shadow_rate     = val[RATE_CFG_W-1:0];
            REG_ADJUST_PERIOD: shadow_period   = val[PERIOD_W-1:0];
            REG_MAX_STEP:      shadow_max_step = val[MAX_STEP_W-1:0];
            default: ;
        endcase
        writes_done++;
    endtask

    // result side backpressure
    initial begin
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_output = 1'b0;
                m_tready <= 1'b1;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            if (pending_time_ms.size() == 0) begin
                $error("time_ms beat with no sample pending: actual %0d", m_tdata);
                fail_count++;
            end else begin
                if (m_tdata !== pending_time_ms[0]) begin
                    $error("time_ms mismatch: expected %0d, actual %0d",
                           pending_time_ms[0], m_tdata);
                    fail_count++;
                end
                void'(pending_time_ms.pop_front());
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("calibrated_cycle_counter_ms_clock_core verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned dt_ms, pick;
        logic [CNT_W-1:0]      cnt;
        logic [CPU_W-1:0]      cpu;
        logic [REF_W-1:0]      rms;
        logic [CFG_DATA_W-1:0] rate_val, period_val, step_val;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                settle_block();
                write_reg(script[i].reg_idx, script[i].value[CFG_DATA_W-1:0]);
            end else begin
                send_sample(script[i].value, script[i].cpu, script[i].rms,
                            script[i].typed, script[i].want);
            end
        end

        foreach (run_count[e]) begin
            run_count[e] = {$urandom, $urandom};
            run_ref[e]   = $urandom;
        end

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            settle_block();
            case ($urandom_range(0, 5))
                0:       rate_val = 32'd1;
                1:       rate_val = 32'hFFFF_FFFF;
                2:       rate_val = '0;
                default: rate_val = $urandom_range(1000, 4_000_000);
            endcase
            period_val = $urandom;
            case ($urandom_range(0, 6))
                0:       period_val[PERIOD_W-1:0] = 20'd1;
                1:       period_val[PERIOD_W-1:0] = '1;
                2:       period_val[PERIOD_W-1:0] = '0;
                default: period_val[PERIOD_W-1:0] = PERIOD_W'($urandom_range(1, 50));
            endcase
            step_val = $urandom;
            case ($urandom_range(0, 6))
                0:       step_val[MAX_STEP_W-1:0] = 22'd1;
                1:       step_val[MAX_STEP_W-1:0] = '1;
                2:       step_val[MAX_STEP_W-1:0] = '0;
                default: step_val[MAX_STEP_W-1:0] = MAX_STEP_W'($urandom_range(1, 5000));
            endcase
            write_reg(REG_INITIAL_RATE, rate_val);
            write_reg(REG_ADJUST_PERIOD, period_val);
            write_reg(REG_MAX_STEP, step_val);

            foreach (speed[e]) speed[e] = 64'($urandom_range(1, 5_000_000));
            if (seg >= NUM_SEGMENTS - 2 || seg == 1) begin
                sender_idles   = 1'b0;
                receiver_idles = 1'b0;
            end else if (seg == 0) begin
                sender_idles   = 1'b1;
                receiver_idles = 1'b1;
            end else begin
                sender_idles   = 1'($urandom_range(0, 1));
                receiver_idles = 1'($urandom_range(0, 1));
            end
            if (seg == 2) hold_output = 1'b1;

            for (int k = 0; k < SEG_ITEMS; k++) begin
                cpu  = CPU_W'($urandom_range(0, CPU_COUNT_DEF - 1));
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    dt_ms = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000)
                                                         : $urandom_range(0, 20);
                    run_count[cpu] = run_count[cpu] + 64'(dt_ms) * speed[cpu]
                                     + 64'($urandom_range(0, 32'(speed[cpu] / 8)));
                    run_ref[cpu]   = run_ref[cpu] + dt_ms;
                    cnt = run_count[cpu];
                    rms = run_ref[cpu];
                end else if (pick < 92) begin
                    cnt = {$urandom, $urandom};
                    rms = $urandom;
                end else if (pick < 96) begin
                    // counter runs backward
                    cnt = run_count[cpu] - 64'($urandom_range(1, 1_000_000));
                    rms = run_ref[cpu];
                end else begin
                    // reference stalls or steps back
                    cnt = run_count[cpu];
                    rms = run_ref[cpu] - $urandom_range(0, 10);
                end
                send_sample(cnt, cpu, rms, 1'b0, '0);
            end
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_time_ms.size() != 0) begin
            $error("%0d time_ms results never arrived", pending_time_ms.size());
            fail_count++;
        end
        $display("Run: %0d samples over %0d clock entries, %0d results checked, %0d reg writes.",
                 samples_sent, CPU_COUNT_DEF, results_checked, writes_done);
        $display("Seen: %0d rate recalibrations, %0d clamped steps, %0d backward deltas.",
                 recal_count, clamp_count, backstep_count);
        if (fail_count == 0) begin
            $display("calibrated_cycle_counter_ms_clock_core verification clean");
        end else begin
            $display("calibrated_cycle_counter_ms_clock_core verification failed");
        end
        $finish;
    end

endmodule
